// File: src/hall_pulse_velocity_estimator_core_defines.svh
// Assertion helpers for the RTL files of the velocity estimator.
`ifndef HALL_PULSE_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH
`define HALL_PULSE_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HPVE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hpve assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HPVE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hpve assertion failed");

`endif

// File: src/hpve_pkg.sv
package hpve_pkg;

  localparam int DATA_W    = 16;
  localparam int NUM_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int HIST_LEN  = 4;
  localparam int AVG_SHIFT = 2;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int WINDOW_LEN_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PW_MAX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PW_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_MIN = 3'd4;

  localparam logic [DATA_W-1:0] PW_MAX_RST  = 16'hFFFF;
  localparam logic [DATA_W-1:0] PW_MIN_RST  = 16'd1;
  localparam logic [NUM_W-1:0]  NUMER_RST   = 32'd1000000;
  localparam logic [DATA_W-1:0] VEL_MAX_RST = 16'hFFFF;
  localparam logic [DATA_W-1:0] VEL_MIN_RST = 16'd0;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SUM    = 5'b00010,
    ST_CLAMP  = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic refill;
    logic sum_step;
    logic clamp;
    logic div_step;
    logic finish_meas;
    logic finish_reset;
  } cmd_t;

endpackage

// File: src/hpve_ctrl.sv
`include "hall_pulse_velocity_estimator_core_defines.svh"

module hpve_ctrl #(
  parameter int WINDOW_LEN = hpve_pkg::WINDOW_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          req_type,
  output logic          out_valid,
  input  logic          out_stall,
  output hpve_pkg::cmd_t cmd
);
  import hpve_pkg::*;

  localparam logic [CNT_W-1:0] SUM_LAST = CNT_W'(WINDOW_LEN - 2);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] count;
  logic             is_reset;
  logic             accept;
  logic             out_free;
  logic             finish;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == ST_FINISH) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = req_type ? ST_FINISH : ST_SUM;
      ST_SUM:    if (count == SUM_LAST) state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_DIV;
      ST_DIV:    if (count == DIV_LAST) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.accept       = accept;
    cmd.refill       = accept && req_type;
    cmd.sum_step     = (state == ST_SUM);
    cmd.clamp        = (state == ST_CLAMP);
    cmd.div_step     = (state == ST_DIV);
    cmd.finish_meas  = finish && !is_reset;
    cmd.finish_reset = finish && is_reset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      is_reset  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        is_reset <= req_type;
      end
      if ((state == ST_SUM && count != SUM_LAST) || (state == ST_DIV && count != DIV_LAST)) begin
        count <= count + 1'b1;
      end else begin
        count <= '0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HPVE_ASSERT_NXT(a_meas_goes_to_sum, accept && !req_type, state == ST_SUM)
  `HPVE_ASSERT_NXT(a_finish_sets_valid, finish, out_valid)
  `HPVE_ASSERT_NXT(a_div_runs_full, state == ST_DIV && count != DIV_LAST, state == ST_DIV)
  `HPVE_ASSERT_IMP(a_finish_one_kind, finish, cmd.finish_meas != cmd.finish_reset)

endmodule

// File: src/hpve_dp.sv
module hpve_dp #(
  parameter int WINDOW_LEN = hpve_pkg::WINDOW_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hpve_pkg::cmd_t                   cmd,
  input  logic                             cfg_valid,
  input  logic [hpve_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpve_pkg::NUM_W-1:0]       cfg_data,
  input  logic [hpve_pkg::DATA_W-1:0]      pulse_width,
  output logic [hpve_pkg::DATA_W-1:0]      velocity,
  output logic [hpve_pkg::DATA_W-1:0]      avg_pulse_width,
  output logic [hpve_pkg::DATA_W-1:0]      velocity_prev1,
  output logic [hpve_pkg::DATA_W-1:0]      velocity_prev2,
  output logic [hpve_pkg::DATA_W-1:0]      velocity_prev3
);
  import hpve_pkg::*;

  localparam int WIN_N = WINDOW_LEN - 1;
  localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);

  logic [DATA_W-1:0] pw_max, pw_min, vel_max, vel_min;
  logic [NUM_W-1:0]  numer;

  logic [DATA_W-1:0] window [WIN_N];
  logic [DATA_W-1:0] pw_reg;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] avg;
  logic [DATA_W-1:0] avg_out;
  logic [DATA_W-1:0] rem;
  logic [NUM_W-1:0]  quo;
  logic [DATA_W-1:0] hist [HIST_LEN];

  logic [SUM_W-1:0]  avg_raw;
  logic [DATA_W-1:0] avg_clamp;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] quo_sat;
  logic [DATA_W-1:0] vel_new;

  // Configuration registers; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pw_max  <= PW_MAX_RST;
      pw_min  <= PW_MIN_RST;
      numer   <= NUMER_RST;
      vel_max <= VEL_MAX_RST;
      vel_min <= VEL_MIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PW_MAX:  pw_max  <= cfg_data[DATA_W-1:0];
        CFG_PW_MIN:  pw_min  <= cfg_data[DATA_W-1:0];
        CFG_NUMER:   numer   <= cfg_data;
        CFG_VEL_MAX: vel_max <= cfg_data[DATA_W-1:0];
        CFG_VEL_MIN: vel_min <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    avg_raw   = sum >> AVG_SHIFT;
    avg_clamp = (avg_raw > SUM_W'(pw_max)) ? pw_max : avg_raw[DATA_W-1:0];
    // The lower limit is applied last so it wins when the limits cross.
    if (avg_clamp < pw_min) begin
      avg_clamp = pw_min;
    end
  end

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, avg};

  always_comb begin
    if (avg == '0) begin
      quo_sat = '0;
    end else if (quo[NUM_W-1:DATA_W] != '0) begin
      quo_sat = '1;
    end else begin
      quo_sat = quo[DATA_W-1:0];
    end
    if (quo_sat > vel_max) begin
      vel_new = vel_max;
    end else if (quo_sat <= vel_min) begin
      vel_new = vel_min;
    end else begin
      vel_new = quo_sat;
    end
  end

  // The window is rotated once per summing step, so after all steps it is
  // back in its original order and the newest width can be shifted in.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_N; i++) begin
        window[i] <= PW_MAX_RST;
      end
    end else if (cmd.refill) begin
      for (int i = 0; i < WIN_N; i++) begin
        window[i] <= pw_max;
      end
    end else if (cmd.sum_step || cmd.clamp) begin
      window[0] <= cmd.clamp ? pw_reg : window[WIN_N-1];
      for (int i = 1; i < WIN_N; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pw_reg <= pulse_width;
      sum    <= SUM_W'(pulse_width);
    end else if (cmd.sum_step) begin
      sum <= sum + SUM_W'(window[WIN_N-1]);
    end
    if (cmd.clamp) begin
      avg <= avg_clamp;
      rem <= '0;
      quo <= numer;
    end else if (cmd.div_step) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.finish_meas) begin
      avg_out <= avg;
    end else if (cmd.finish_reset) begin
      avg_out <= pw_max;
    end
  end

  // History, oldest first; the newest entry is the reported velocity.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish_reset) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist[i] <= '0;
      end
    end else if (cmd.finish_meas) begin
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[HIST_LEN-1] <= vel_new;
    end
  end

  assign velocity        = hist[3];
  assign velocity_prev1  = hist[2];
  assign velocity_prev2  = hist[1];
  assign velocity_prev3  = hist[0];
  assign avg_pulse_width = avg_out;

endmodule

// File: src/hall_pulse_velocity_estimator_core.sv
// Hall pulse velocity estimator.
// Input channel (in_valid / in_stall) carries req_type and pulse_width. A
// measurement transaction averages the width with the previous WINDOW_LEN-1
// widths, clamps the average, divides speed_numerator by it and clamps the
// velocity. A reset transaction refills the window and clears the history.
// Output channel (out_valid / out_stall) returns one result per input
// transaction: velocity, avg_pulse_width and the three previous velocities.
// A measurement runs from acceptance through WINDOW_LEN-1 summing steps, one
// clamp step, the 32 steps of the radix-2 restoring divider and a final step
// that loads the result register; a reset transaction goes straight to the
// final step. One transaction is in work at a time; in_stall is high until the
// result has been loaded, so no new input is taken before the last one is
// through. A result waiting under out_stall does not hold off the next input
// transaction, but the next result waits in its final state until the output
// register frees up. Configuration (cfg_valid / cfg_ready, always ready) is to
// be written by the user only while idle; the block does not enforce this.
// Synchronous reset restores the register defaults, fills the window with the
// maximum width and clears the history and the output valid flag.
module hall_pulse_velocity_estimator_core #(
  parameter int WINDOW_LEN = hpve_pkg::WINDOW_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [hpve_pkg::DATA_W-1:0]    pulse_width,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hpve_pkg::DATA_W-1:0]    velocity,
  output logic [hpve_pkg::DATA_W-1:0]    avg_pulse_width,
  output logic [hpve_pkg::DATA_W-1:0]    velocity_prev1,
  output logic [hpve_pkg::DATA_W-1:0]    velocity_prev2,
  output logic [hpve_pkg::DATA_W-1:0]    velocity_prev3,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hpve_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpve_pkg::NUM_W-1:0]     cfg_data
);
  import hpve_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  hpve_ctrl #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  hpve_dp #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pulse_width    (pulse_width),
    .velocity       (velocity),
    .avg_pulse_width(avg_pulse_width),
    .velocity_prev1 (velocity_prev1),
    .velocity_prev2 (velocity_prev2),
    .velocity_prev3 (velocity_prev3)
  );

endmodule
